// File: rtl/spcd_pkg.sv
`default_nettype none
package spcd_pkg;
   localparam int CandCount = 12;
   localparam logic [11:0] CandAll = 12'hFFF;
   localparam logic [11:0] PrefixMask = 12'h0FE;

   localparam logic [3:0] CMD_NONE    = 4'd0;
   localparam logic [3:0] CMD_LED     = 4'd1;
   localparam logic [3:0] CMD_PERIOD  = 4'd2;
   localparam logic [3:0] CMD_PHASE   = 4'd3;
   localparam logic [3:0] CMD_DP1     = 4'd4;
   localparam logic [3:0] CMD_DS2     = 4'd7;
   localparam logic [3:0] CMD_SYNC    = 4'd8;
   localparam logic [3:0] CMD_PWMS_OFF = 4'd12;

   localparam logic [1:0] CSR_INITIAL_PERIOD = 2'd0;

   localparam logic [7:0] CHAR_LF = 8'd10;
   localparam logic [7:0] CHAR_CR = 8'd13;
   localparam logic [7:0] CHAR_NUL = 8'd0;

   function automatic logic [2:0] kw_len(input int i);
      logic [2:0] r;
      case (i)
         0: r = 3'd3; 1: r = 3'd4; 2: r = 3'd3; 3: r = 3'd4; 4: r = 3'd4;
         5: r = 3'd4; 6: r = 3'd4; 7: r = 3'd5; 8: r = 3'd6; 9: r = 3'd7;
         10: r = 3'd6; 11: r = 3'd7;
         default: r = 3'd0;
      endcase
      return r;
   endfunction

   function automatic logic [7:0] kw_char(input int i, input logic [2:0] p);
      logic [55:0] s;
      logic [7:0] r;
      case (i)
         0: s = {"led", 32'h0};
         1: s = {"PER:", 24'h0};
         2: s = {"PS:", 32'h0};
         3: s = {"DP1:", 24'h0};
         4: s = {"DP2:", 24'h0};
         5: s = {"DS1:", 24'h0};
         6: s = {"DS2:", 24'h0};
         7: s = {"SYNC:", 16'h0};
         8: s = {"pwmpon", 8'h0};
         9: s = "pwmpoff";
         10: s = {"pwmson", 8'h0};
         11: s = "pwmsoff";
         default: s = '0;
      endcase
      case (p)
         3'd0: r = s[55:48]; 3'd1: r = s[47:40]; 3'd2: r = s[39:32];
         3'd3: r = s[31:24]; 3'd4: r = s[23:16]; 3'd5: r = s[15:8];
         3'd6: r = s[7:0];
         default: r = 8'h0;
      endcase
      return r;
   endfunction

   typedef struct packed {
      logic        start;
      logic [31:0] dividend;
      logic [16:0] divisor;
   } div_req_type;

   typedef struct packed {
      logic        done;
      logic [31:0] quotient;
   } div_rsp_type;
endpackage
`default_nettype wire

// File: rtl/spcd_divider.sv
`default_nettype none
module spcd_divider (
   input  wire logic               clock,
   input  wire logic               reset,
   input  wire spcd_pkg::div_req_type req,
   output spcd_pkg::div_rsp_type   rsp
);
   logic [31:0] quo_ff, quo_in;
   logic [16:0] rem_ff, rem_in;
   logic [16:0] dsr_ff, dsr_in;
   logic [5:0]  cnt_ff, cnt_in;
   logic        busy_ff, busy_in;
   logic        done_ff, done_in;
   logic [17:0] trial;

   always_comb begin
      quo_in = quo_ff;
      rem_in = rem_ff;
      dsr_in = dsr_ff;
      cnt_in = cnt_ff;
      busy_in = busy_ff;
      done_in = 1'b0;
      trial = {rem_ff, quo_ff[31]} - {1'b0, dsr_ff};
      if (req.start) begin
         quo_in = req.dividend;
         rem_in = '0;
         dsr_in = req.divisor;
         cnt_in = 6'd0;
         busy_in = 1'b1;
      end else if (busy_ff) begin
         if (!trial[17]) begin
            rem_in = trial[16:0];
            quo_in = {quo_ff[30:0], 1'b1};
         end else begin
            rem_in = {rem_ff[15:0], quo_ff[31]};
            quo_in = {quo_ff[30:0], 1'b0};
         end
         cnt_in = cnt_ff + 6'd1;
         if (cnt_ff == 6'd31) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      quo_ff <= quo_in;
      rem_ff <= rem_in;
      dsr_ff <= dsr_in;
      cnt_ff <= cnt_in;
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
      end
   end

   assign rsp.done = done_ff;
   assign rsp.quotient = quo_ff;
endmodule
`default_nettype wire

// File: rtl/serial_pwm_command_decoder_core.sv
`default_nettype none
// channel | direction | handshake         | payload
// req     | in        | req_valid/stall   | req_rx_byte
// rsp     | out       | rsp_valid/stall   | command and seven value fields
// csr     | in        | apb psel/penable  | initial_period at 0x0
// an ordinary byte goes from idle to the char state, a line end to the end state
// each division in the shared radix-2 divider is a start state, then a wait for done
// period lines run phase and sync steps; phase and sync lines run only their own
// synchronous reset returns to idle with period 999, sync 499, led on
// rsp is held in an output register; req_stall is high while a word is worked
// on or a result waits, so an output stall adds its own length
module serial_pwm_command_decoder_core #(
   parameter int LINE_CAPACITY = 256
) (
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        req_valid,
   output logic             req_stall,
   input  wire logic [7:0]  req_rx_byte,
   output logic             rsp_valid,
   input  wire logic        rsp_stall,
   output logic [3:0]       rsp_command,
   output logic             rsp_led_state,
   output logic [15:0]      rsp_period_value,
   output logic [15:0]      rsp_compare_value,
   output logic             rsp_period_written_first,
   output logic [15:0]      rsp_primary_phase,
   output logic [15:0]      rsp_secondary_phase,
   output logic [15:0]      rsp_dead_band,
   input  wire logic        psel,
   input  wire logic        penable,
   input  wire logic        pwrite,
   input  wire logic [1:0]  paddr,
   input  wire logic [31:0] pwdata,
   output logic [31:0]      prdata,
   output logic             pready
);
   localparam int PosW = $clog2(LINE_CAPACITY);
   localparam logic [PosW-1:0] PosLast = PosW'(LINE_CAPACITY - 1);

   localparam logic [3:0] S_IDLE  = 4'd0;
   localparam logic [3:0] S_CHAR  = 4'd1;
   localparam logic [3:0] S_END   = 4'd2;
   localparam logic [3:0] S_MUL1  = 4'd3;
   localparam logic [3:0] S_MUL2  = 4'd4;
   localparam logic [3:0] S_PDIV  = 4'd5;
   localparam logic [3:0] S_SMUL  = 4'd6;
   localparam logic [3:0] S_SDIV  = 4'd7;
   localparam logic [3:0] S_OUT   = 4'd8;
   localparam logic [3:0] S_PWAIT = 4'd9;
   localparam logic [3:0] S_SWAIT = 4'd10;

   logic [3:0]      state_ff, state_in;
   logic [7:0]      byte_ff, byte_in;
   logic [PosW-1:0] pos_ff, pos_in;
   logic            ended_ff, ended_in;
   logic [11:0]     cand_ff, cand_in;
   logic [15:0]     acc_ff, acc_in;
   logic            stop_ff, stop_in;
   logic [15:0]     init_ff, init_in;
   logic [15:0]     per_ff, per_in;
   logic [15:0]     dly_ff, dly_in;
   logic [15:0]     sync_ff, sync_in;
   logic            led_ff, led_in;
   logic [3:0]      cmd_ff, cmd_in;
   logic [31:0]     prod_ff, prod_in;
   logic            wf_ff, wf_in;
   logic [15:0]     cmp_ff, cmp_in;
   logic [15:0]     prim_ff, prim_in;
   logic [15:0]     sec_ff, sec_in;
   logic [15:0]     dead_ff, dead_in;

   logic [15:0] mul_a, mul_b;
   logic [31:0] mul_p;
   spcd_pkg::div_req_type dreq;
   spcd_pkg::div_rsp_type drsp;
   logic        in_num;
   logic [11:0] fed, closed;
   logic [3:0]  first;
   logic [16:0] per_p1;
   logic        cfg_wr;

   spcd_divider u_div (.clock(clock), .reset(reset), .req(dreq), .rsp(drsp));

   assign mul_p = mul_a * mul_b;
   assign cfg_wr = psel && penable && pwrite && (paddr == spcd_pkg::CSR_INITIAL_PERIOD);
   assign pready = 1'b1;
   assign prdata = (paddr == spcd_pkg::CSR_INITIAL_PERIOD) ? {16'h0, init_ff} : 32'h0;
   assign req_stall = (state_ff != S_IDLE);
   assign per_p1 = {1'b0, per_ff} + 17'd1;

   always_comb begin
      fed = cand_ff;
      in_num = 1'b0;
      closed = cand_ff;
      for (int i = 0; i < spcd_pkg::CandCount; i++) begin
         if (cand_ff[i]) begin
            if (pos_ff < PosW'(spcd_pkg::kw_len(i))) begin
               if (spcd_pkg::kw_char(i, pos_ff[2:0]) != byte_ff) fed[i] = 1'b0;
            end else if (!spcd_pkg::PrefixMask[i]) begin
               fed[i] = 1'b0;
            end else begin
               in_num = 1'b1;
            end
         end
         if (pos_ff < PosW'(spcd_pkg::kw_len(i))) closed[i] = 1'b0;
      end
      first = spcd_pkg::CMD_NONE;
      for (int i = spcd_pkg::CandCount - 1; i >= 0; i--)
         if (closed[i]) first = 4'(i + 1);
   end

   always_comb begin
      state_in = state_ff; byte_in = byte_ff; pos_in = pos_ff; ended_in = ended_ff;
      cand_in = cand_ff; acc_in = acc_ff; stop_in = stop_ff; init_in = init_ff;
      per_in = per_ff; dly_in = dly_ff; sync_in = sync_ff; led_in = led_ff;
      cmd_in = cmd_ff; prod_in = prod_ff; wf_in = wf_ff; cmp_in = cmp_ff;
      prim_in = prim_ff; sec_in = sec_ff; dead_in = dead_ff;
      mul_a = '0; mul_b = '0;
      dreq.start = 1'b0; dreq.dividend = prod_ff; dreq.divisor = {1'b0, init_ff};
      if (cfg_wr) begin
         init_in = pwdata[15:0];
         per_in = pwdata[15:0];
      end
      case (state_ff)
         S_IDLE: begin
            if (req_valid) begin
               byte_in = req_rx_byte;
               state_in = (req_rx_byte == spcd_pkg::CHAR_LF || req_rx_byte == spcd_pkg::CHAR_CR)
                          ? S_END : S_CHAR;
            end
         end
         S_CHAR: begin
            if (pos_ff != PosLast) begin
               if (!ended_ff) begin
                  if (byte_ff == spcd_pkg::CHAR_NUL) begin
                     cand_in = closed;
                     ended_in = 1'b1;
                  end else begin
                     cand_in = fed;
                     if (in_num && !stop_ff) begin
                        if (byte_ff >= "0" && byte_ff <= "9")
                           acc_in = 16'((acc_ff * 16'd10) + {8'h0, byte_ff - 8'd48});
                        else
                           stop_in = 1'b1;
                     end
                  end
               end
               pos_in = pos_ff + 1'b1;
            end else begin
               pos_in = '0; ended_in = 1'b0; cand_in = spcd_pkg::CandAll;
               acc_in = '0; stop_in = 1'b0;
            end
            state_in = S_IDLE;
         end
         S_END: begin
            cmd_in = first; wf_in = 1'b0; cmp_in = '0; prim_in = '0;
            sec_in = '0; dead_in = '0;
            state_in = S_OUT;
            case (first)
               spcd_pkg::CMD_LED: led_in = ~led_ff;
               spcd_pkg::CMD_PERIOD: begin
                  wf_in = acc_ff > per_ff;
                  per_in = acc_ff;
                  cmp_in = 16'((({1'b0, acc_ff} + 17'd1) >> 1) - 17'd1);
                  state_in = S_MUL1;
               end
               spcd_pkg::CMD_PHASE: begin
                  dly_in = acc_ff;
                  state_in = S_MUL1;
               end
               spcd_pkg::CMD_SYNC: begin
                  sync_in = acc_ff;
                  state_in = S_SMUL;
               end
               default: begin
                  if (first >= spcd_pkg::CMD_DP1 && first <= spcd_pkg::CMD_DS2)
                     dead_in = acc_ff;
               end
            endcase
         end
         S_MUL1: begin
            mul_a = dly_ff;
            mul_b = (cmd_ff == spcd_pkg::CMD_PERIOD) ? per_ff : per_p1[15:0];
            prod_in = mul_p;
            state_in = S_MUL2;
         end
         S_MUL2: begin
            mul_a = dly_ff;
            mul_b = (cmd_ff == spcd_pkg::CMD_PERIOD) ? 16'd0 : {15'd0, per_p1[16]};
            prod_in = {prod_ff[30:0], 1'b0} + {mul_p[14:0], 17'd0};
            if (init_ff == 16'd0) begin
               prim_in = 16'd1;
               state_in = (cmd_ff == spcd_pkg::CMD_PERIOD) ? S_SMUL : S_OUT;
            end else begin
               state_in = S_PDIV;
            end
         end
         S_PDIV: begin
            dreq.start = 1'b1;
            state_in = S_PWAIT;
         end
         S_PWAIT: begin
            if (drsp.done) begin
               prim_in = 16'(16'd0 - drsp.quotient[15:0]);
               state_in = (cmd_ff == spcd_pkg::CMD_PERIOD) ? S_SMUL : S_OUT;
            end
         end
         S_SMUL: begin
            mul_a = 16'(sync_ff + 16'd1);
            mul_b = per_p1[15:0];
            prod_in = mul_p;
            if (sync_ff == 16'hFFFF) prod_in = {per_p1[15:0], 16'h0};
            else if (per_p1[16]) prod_in = {(16'(sync_ff + 16'd1)), 16'h0};
            if (sync_ff == 16'hFFFF && per_p1[16]) prod_in = '0;
            state_in = S_SDIV;
         end
         S_SDIV: begin
            dreq.start = 1'b1;
            dreq.divisor = {1'b0, init_ff} + 17'd1;
            state_in = S_SWAIT;
         end
         S_SWAIT: begin
            if (drsp.done) begin
               sec_in = 16'(drsp.quotient[15:0] - 16'd1);
               state_in = S_OUT;
            end
         end
         S_OUT: begin
            if (!rsp_stall) begin
               pos_in = '0; ended_in = 1'b0; cand_in = spcd_pkg::CandAll;
               acc_in = '0; stop_in = 1'b0;
               state_in = S_IDLE;
            end
         end
         default: state_in = S_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      byte_ff <= byte_in; cmd_ff <= cmd_in; prod_ff <= prod_in; wf_ff <= wf_in;
      cmp_ff <= cmp_in; prim_ff <= prim_in; sec_ff <= sec_in; dead_ff <= dead_in;
      if (reset) begin
         state_ff <= S_IDLE; pos_ff <= '0; ended_ff <= 1'b0;
         cand_ff <= spcd_pkg::CandAll; acc_ff <= '0; stop_ff <= 1'b0;
         init_ff <= 16'd999; per_ff <= 16'd999; dly_ff <= '0; sync_ff <= 16'd499;
         led_ff <= 1'b1;
      end else begin
         state_ff <= state_in; pos_ff <= pos_in; ended_ff <= ended_in;
         cand_ff <= cand_in; acc_ff <= acc_in; stop_ff <= stop_in;
         init_ff <= init_in; per_ff <= per_in; dly_ff <= dly_in; sync_ff <= sync_in;
         led_ff <= led_in;
      end
   end

   assign rsp_valid = (state_ff == S_OUT);
   assign rsp_command = cmd_ff;
   assign rsp_led_state = led_ff;
   assign rsp_period_value = per_ff;
   assign rsp_compare_value = cmp_ff;
   assign rsp_period_written_first = wf_ff;
   assign rsp_primary_phase = prim_ff;
   assign rsp_secondary_phase = sec_ff;
   assign rsp_dead_band = dead_ff;
endmodule
`default_nettype wire

// File: rtl/spcd_checker.sv
`default_nettype none
module spcd_checker (
   input wire logic       clock,
   input wire logic       reset,
   input wire logic       req_stall,
   input wire logic       rsp_valid,
   input wire logic       rsp_stall,
   input wire logic [3:0] rsp_command,
   input wire logic [15:0] rsp_compare_value,
   input wire logic [15:0] rsp_dead_band
);
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp_command))
      else $error("rsp word changed under stall");
   a_busy_out: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> req_stall)
      else $error("input taken while result pending");
   a_cmd_range: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> rsp_command <= spcd_pkg::CMD_PWMS_OFF)
      else $error("bad command code");
   a_cmp_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_command != spcd_pkg::CMD_PERIOD |-> rsp_compare_value == 16'd0)
      else $error("compare set on other command");
   a_dead_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && (rsp_command < spcd_pkg::CMD_DP1 || rsp_command > spcd_pkg::CMD_DS2)
      |-> rsp_dead_band == 16'd0)
      else $error("dead band set on other command");
endmodule

bind serial_pwm_command_decoder_core spcd_checker u_chk (
   .clock(clock), .reset(reset), .req_stall(req_stall),
   .rsp_valid(rsp_valid), .rsp_stall(rsp_stall), .rsp_command(rsp_command),
   .rsp_compare_value(rsp_compare_value), .rsp_dead_band(rsp_dead_band)
);
`default_nettype wire
